FILE: rtl/mis_pkg.sv
package mis_pkg;

  localparam int WIN_LEN   = 10;
  localparam int PND_DEPTH = WIN_LEN + 1;

  localparam logic [7:0] REX_W_48   = 8'h48;
  localparam logic [7:0] REX_WB_49  = 8'h49;
  localparam logic [7:0] REX_WR_4C  = 8'h4C;
  localparam logic [7:0] REX_WRB_4D = 8'h4D;
  localparam logic [7:0] OPC_MASK   = 8'hF8;
  localparam logic [7:0] OPC_MOV_RI = 8'hB8;
  localparam logic [7:0] REX_B_41   = 8'h41;

  localparam logic [3:0] LEN_SHORT   = 4'd5;
  localparam logic [3:0] LEN_SHORT_B = 4'd6;
  localparam logic [3:0] LEN_FULL    = 4'd10;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       stream_end;
  } mis_entry_t;

endpackage

FILE: rtl/movabs_immediate_shrinker.sv
// Results pass through the pending buffer into the output register. Throughput: one input
// byte per cycle while each byte yields at most one result byte and the output is not stalled.
// A byte that yields several results is drained from an 11-entry pending buffer at one result
// per cycle while the output accepts; in_tready drops while more than one entry is pending.
// Reset (rst_n low, synchronous) empties the window, the pending buffer and the output register.
module movabs_immediate_shrinker
  import mis_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [0:0] out_tuser   // [0] out_stream_end
);

  logic [7:0]  win_r   [WIN_LEN-1];
  logic [7:0]  win_nxt [WIN_LEN-1];
  logic [3:0]  win_cnt_r, win_cnt_nxt;

  mis_entry_t  pnd_r   [PND_DEPTH];
  mis_entry_t  pnd_nxt [PND_DEPTH];
  mis_entry_t  pnd_sh  [PND_DEPTH];
  logic [3:0]  pnd_cnt_r, pnd_cnt_nxt;

  logic        out_valid_r, out_valid_nxt;
  mis_entry_t  out_r, out_nxt;

  logic [7:0]  w     [WIN_LEN];
  logic [7:0]  res_b [WIN_LEN];
  mis_entry_t  res_e [WIN_LEN];
  logic [3:0]  res_k;
  logic        full;
  logic        is_mov;
  logic        fits;
  logic        in_acc;
  logic        shift;
  logic [3:0]  base;

  assign in_acc = in_tvalid && in_tready;

  always_comb begin
    for (int j = 0; j < WIN_LEN - 1; j++) begin
      w[j] = (win_cnt_r == 4'(j)) ? in_tdata : win_r[j];
    end
    w[WIN_LEN-1] = in_tdata;
    full   = (win_cnt_r == 4'(WIN_LEN - 1));
    is_mov = ((w[0] == REX_W_48) || (w[0] == REX_WB_49) ||
              (w[0] == REX_WR_4C) || (w[0] == REX_WRB_4D)) &&
             ((w[1] & OPC_MASK) == OPC_MOV_RI);
    fits   = ((w[6] | w[7] | w[8] | w[9]) == 8'h00);

    for (int j = 0; j < WIN_LEN; j++) begin
      res_b[j] = w[j];
    end
    res_k = '0;
    if (full && is_mov) begin
      if (fits) begin
        if (w[0][0]) begin
          res_b[0] = REX_B_41;
          res_b[1] = OPC_MOV_RI | {5'b0, w[1][2:0]};
          for (int j = 2; j < 6; j++) begin
            res_b[j] = w[j];
          end
          res_k = LEN_SHORT_B;
        end else begin
          res_b[0] = OPC_MOV_RI | {5'b0, w[1][2:0]};
          for (int j = 1; j < 5; j++) begin
            res_b[j] = w[j+1];
          end
          res_k = LEN_SHORT;
        end
      end else begin
        res_k = LEN_FULL;
      end
    end else if (in_tlast) begin
      res_k = win_cnt_r + 4'd1;
    end else if (full) begin
      res_k = 4'd1;
    end

    for (int j = 0; j < WIN_LEN; j++) begin
      res_e[j].data       = res_b[j];
      res_e[j].run_end    = ((4'(j) + 4'd1) == res_k);
      res_e[j].stream_end = ((4'(j) + 4'd1) == res_k) && in_tlast;
    end

    win_cnt_nxt = win_cnt_r;
    for (int j = 0; j < WIN_LEN - 1; j++) begin
      win_nxt[j] = win_r[j];
    end
    if (in_acc) begin
      if (in_tlast || (full && is_mov)) begin
        win_cnt_nxt = '0;
      end else if (full) begin
        win_cnt_nxt = 4'(WIN_LEN - 1);
        for (int j = 0; j < WIN_LEN - 1; j++) begin
          win_nxt[j] = w[j+1];
        end
      end else begin
        win_cnt_nxt = win_cnt_r + 4'd1;
        for (int j = 0; j < WIN_LEN - 1; j++) begin
          win_nxt[j] = w[j];
        end
      end
    end
  end

  always_comb begin
    shift = (pnd_cnt_r != 4'd0) && (!out_valid_r || out_tready);
    base  = pnd_cnt_r - {3'b000, shift};
    for (int j = 0; j < PND_DEPTH - 1; j++) begin
      pnd_sh[j] = shift ? pnd_r[j+1] : pnd_r[j];
    end
    pnd_sh[PND_DEPTH-1] = pnd_r[PND_DEPTH-1];
    for (int j = 0; j < PND_DEPTH; j++) begin
      pnd_nxt[j] = pnd_sh[j];
    end
    for (int j = 0; j < WIN_LEN; j++) begin
      if (in_acc && (base == 4'd0) && (4'(j) < res_k)) begin
        pnd_nxt[j] = res_e[j];
      end
    end
    for (int j = 1; j < PND_DEPTH; j++) begin
      if (in_acc && (base == 4'd1) && (4'(j - 1) < res_k)) begin
        pnd_nxt[j] = res_e[j-1];
      end
    end
    pnd_cnt_nxt = base + (in_acc ? res_k : 4'd0);

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (shift) begin
      out_nxt       = pnd_r[0];
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r   <= '0;
      pnd_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      win_cnt_r   <= win_cnt_nxt;
      pnd_cnt_r   <= pnd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    pnd_r <= pnd_nxt;
    out_r <= out_nxt;
  end

  assign in_tready    = (pnd_cnt_r <= 4'd1);
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_r.data;
  assign out_tlast    = out_r.run_end;
  assign out_tuser[0] = out_r.stream_end;

`ifndef SYNTHESIS
  a_pnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pnd_cnt_r <= 4'(PND_DEPTH))
    else $error("Pending buffer count exceeds its depth.");

  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    win_cnt_r <= 4'(WIN_LEN - 1))
    else $error("Window holds more than nine bytes between transfers.");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> (win_cnt_r == 4'd0))
    else $error("Window not emptied after the final byte of a stream.");

  a_stream_end_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("Stream end flagged on a byte that does not end its run.");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    ((pnd_cnt_r != 4'd0) && !out_valid_r) |=> out_valid_r)
    else $error("Pending byte not moved into a free output register.");
`endif

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mis_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;
  logic [0:0] out_tuser;          // [0] out_stream_end

  logic [8:0] feed_q[$];
  mis_entry_t want_q[$];
  logic [7:0] win [WIN_LEN];
  int         win_cnt = 0;
  int         fail_cnt = 0;
  int         idle_cnt = 0;
  int         in_gap = 0;
  int         out_stall = 0;
  int         in_calm = 0;
  int         out_calm = 0;
  logic       in_xfer = 1'b0;

  movabs_immediate_shrinker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_rex_w();
    case ($urandom_range(0, 3))
      0: return REX_W_48;
      1: return REX_WB_49;
      2: return REX_WR_4C;
      default: return REX_WRB_4D;
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic last);
    feed_q.push_back({last, b});
  endtask

  task automatic add_movabs(input logic [7:0] pfx, input logic [2:0] reg_n,
                            input logic [31:0] lo, input logic [31:0] hi,
                            input logic last_end);
    push_byte(pfx, 1'b0);
    push_byte(OPC_MOV_RI | {5'd0, reg_n}, 1'b0);
    for (int i = 0; i < 4; i++) push_byte(lo[8*i +: 8], 1'b0);
    for (int i = 0; i < 4; i++) push_byte(hi[8*i +: 8], last_end && (i == 3));
  endtask

  // Runs one accepted byte through the window and queues the bytes it releases.
  task automatic shrink_step(input logic [7:0] b, input logic last);
    mis_entry_t res[$];
    mis_entry_t e;
    logic [7:0] p;
    logic [7:0] op;
    logic       hit;
    if (win_cnt >= WIN_LEN) win_cnt = WIN_LEN - 1;
    win[win_cnt] = b;
    win_cnt++;
    if (win_cnt == WIN_LEN) begin
      p = win[0];
      op = win[1];
      hit = (p == REX_W_48 || p == REX_WB_49 || p == REX_WR_4C || p == REX_WRB_4D) &&
            ((op & OPC_MASK) == OPC_MOV_RI);
      if (!hit) begin
        res.push_back('{data: p, run_end: 1'b0, stream_end: 1'b0});
        for (int j = 0; j < WIN_LEN - 1; j++) win[j] = win[j + 1];
        win_cnt--;
      end else begin
        if ((win[6] | win[7] | win[8] | win[9]) == 8'h00) begin
          if (p[0]) res.push_back('{data: REX_B_41, run_end: 1'b0, stream_end: 1'b0});
          res.push_back('{data: OPC_MOV_RI | {5'd0, op[2:0]}, run_end: 1'b0,
                          stream_end: 1'b0});
          for (int j = 2; j < 6; j++)
            res.push_back('{data: win[j], run_end: 1'b0, stream_end: 1'b0});
        end else begin
          for (int j = 0; j < WIN_LEN; j++)
            res.push_back('{data: win[j], run_end: 1'b0, stream_end: 1'b0});
        end
        win_cnt = 0;
      end
    end
    if (last) begin
      for (int j = 0; j < win_cnt; j++)
        res.push_back('{data: win[j], run_end: 1'b0, stream_end: 1'b0});
      win_cnt = 0;
      if (res.size() > 0) begin
        e = res[res.size() - 1];
        e.stream_end = 1'b1;
        res[res.size() - 1] = e;
      end
    end
    if (res.size() > 0) begin
      e = res[res.size() - 1];
      e.run_end = 1'b1;
      res[res.size() - 1] = e;
    end
    foreach (res[i]) want_q.push_back(res[i]);
  endtask

  always @(negedge clk) begin
    logic [8:0] item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_xfer) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        item = feed_q.pop_front();
        in_tdata <= item[7:0];
        in_tlast <= item[8];
        in_tvalid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap(out_calm);
    end
  end

  always @(posedge clk) begin
    mis_entry_t want;
    in_xfer <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) shrink_step(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (want_q.size() == 0) begin
        $display("%0t: unexpected output transfer data=%02h last=%b user=%b",
                 $time, out_tdata, out_tlast, out_tuser[0]);
        fail_cnt++;
      end else begin
        want = want_q.pop_front();
        if (out_tdata !== want.data) begin
          $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_tdata);
          fail_cnt++;
        end
        if (out_tlast !== want.run_end) begin
          $display("%0t: out_run_end expected %b actual %b", $time, want.run_end, out_tlast);
          fail_cnt++;
        end
        if (out_tuser[0] !== want.stream_end) begin
          $display("%0t: out_stream_end expected %b actual %b",
                   $time, want.stream_end, out_tuser[0]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int r;
    int n;
    logic [31:0] hi;
    logic [7:0] op;

    add_movabs(REX_W_48, 3'd0, 32'h04030201, 32'h0, 1'b0);
    add_movabs(REX_WRB_4D, 3'd7, 32'hFFFFFFFF, 32'h0, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);

    while (feed_q.size() < 218) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        r = $urandom_range(0, 9);
        if (r < 6) hi = 32'h0;
        else if (r < 8) hi = $urandom;
        else if (r == 8) hi = 32'hFFFFFFFF;
        else hi = 32'h1 << $urandom_range(0, 31);
        add_movabs(pick_rex_w(), 3'($urandom_range(0, 7)), $urandom, hi,
                   $urandom_range(0, 9) == 0);
      end else if (kind < 72) begin
        push_byte(pick_rex_w(), 1'b0);
        push_byte(OPC_MOV_RI | 8'($urandom_range(0, 7)), 1'b0);
        n = $urandom_range(0, 7);
        for (int i = 0; i < n; i++) push_byte(8'($urandom), 1'b0);
        push_byte(8'($urandom), 1'b1);
      end else if (kind < 85) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_byte(8'($urandom), (i == n - 1) && ($urandom_range(0, 9) == 0));
      end else begin
        if ($urandom_range(0, 1) == 0) push_byte(pick_rex_w(), 1'b0);
        else push_byte(8'h40 | 8'($urandom_range(0, 7)), 1'b0);
        do op = 8'($urandom); while ((op & OPC_MASK) == OPC_MOV_RI);
        if ($urandom_range(0, 2) == 0) op = OPC_MOV_RI | 8'($urandom_range(0, 7));
        push_byte(op, $urandom_range(0, 9) == 0);
      end
    end
    push_byte(8'($urandom), 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (feed_q.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    while (want_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (want_q.size() > 0) begin
      $display("%0t: %0d expected output bytes never arrived", $time, want_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
